// ===== rtl/core/tgr_pkg.sv =====
package tgr_pkg;

   // input item kinds
   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_GLYPH = 2'd1;
   localparam logic [1:0] KIND_TOTAL = 2'd2;

   // configuration register indexes
   localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
   localparam logic [2:0] REG_FRAME_WIDTH   = 3'd2;
   localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd3;
   localparam logic [2:0] REG_DEFAULT_COLOR = 3'd4;

   // character codes
   localparam logic [7:0] CH_NEWLINE  = 8'h0a;
   localparam logic [7:0] CH_FORMFEED = 8'h0c;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_DEL      = 8'h7f;
   localparam logic [7:0] CH_LPAREN   = 8'h28;
   localparam logic [7:0] CH_RPAREN   = 8'h29;
   localparam logic [7:0] CH_0        = 8'h30;
   localparam logic [7:0] CH_9        = 8'h39;
   localparam logic [7:0] CH_UA       = 8'h41;
   localparam logic [7:0] CH_UF       = 8'h46;
   localparam logic [7:0] CH_LA       = 8'h61;
   localparam logic [7:0] CH_LF       = 8'h66;

   // glyph word layout: bit 14 top-left, rows of three, bit 15 drops one row
   localparam int unsigned GLYPH_ROWS = 5;
   localparam int unsigned GLYPH_COLS = 3;
   localparam logic [14:0] COL0_BITS  = 15'h4924;
   localparam logic [14:0] COL1_BITS  = 15'h2492;
   localparam logic [14:0] COL2_BITS  = 15'h1249;
   localparam logic [7:0]  COLOR_ALPHA = 8'hff;

   typedef struct packed {
      logic accept;
      logic glyph;
      logic emit_pixel;
      logic emit_total;
   } tgr_cmd_type;

   typedef struct packed {
      logic draw;
      logic total;
      logic mask_any;
      logic mask_one;
      logic out_free;
   } tgr_status_type;

endpackage

// ===== rtl/core/text_glyph_rasterizer.sv =====
// 3x5 bitmap font text renderer.
// req_*: one item per transfer: a text byte, a glyph store write or an end of
//   string. Load the glyph store before drawing any code that uses it.
// rsp_*: pixel writes (x, y, colour) clipped to the frame, or one total
//   advance result at end of string; rsp_last marks the final result of an item.
// csr_*: register writes, always ready; write only while the block is idle.
// Flow: a store write or a control, escape or non-printable byte is handled
//   as it is accepted. A printable code starts its store read as it is accepted,
//   then the glyph state builds the clipped pixel mask, then its pixels (0 to
//   15) go out one pixel per cycle while the result register is free. End of
//   string passes its total through the total state to the result register.
//   The glyph store has a single read port.
// The result register holds one result; when rsp_ready is low the pixel loop
//   waits on it, and a new item is taken once the current one has handed its
//   last result to that register.
// Reset clears the cursor to the origin, the colour to the default colour and
//   the registers to their reset values; glyph store contents are undefined.
module text_glyph_rasterizer #(
   parameter int GLYPH_COUNT = 96,
   parameter int COORD_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [7:0]         req_text_byte,
   input  logic [6:0]         req_glyph_index,
   input  logic [15:0]        req_glyph_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_is_total,
   output logic signed [15:0] rsp_pixel_x,
   output logic signed [15:0] rsp_pixel_y,
   output logic [31:0]        rsp_pixel_color,
   output logic signed [15:0] rsp_total_width,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import tgr_pkg::*;

   tgr_cmd_type    cmd;
   tgr_status_type status;

   assign csr_ready = 1'b1;

   tgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tgr_dp #(
      .GLYPH_COUNT (GLYPH_COUNT),
      .COORD_BITS  (COORD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_text_byte   (req_text_byte),
      .req_glyph_index (req_glyph_index),
      .req_glyph_word  (req_glyph_word),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_is_total    (rsp_is_total),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_total_width (rsp_total_width),
      .rsp_last        (rsp_last)
   );

`ifndef SYNTHESIS
   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_pixel || cmd.emit_total) |-> status.out_free)
      else $error("result loaded while the result register is still full");

   a_total_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == KIND_TOTAL) |=> !req_ready)
      else $error("new item taken before the end-of-string total was issued");

   a_total_result: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_total |=> (rsp_valid && rsp_is_total && rsp_last))
      else $error("end-of-string total not presented as a final result");

   a_no_accept_while_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !(cmd.emit_pixel || cmd.emit_total || cmd.glyph))
      else $error("item accepted while a glyph is still being drawn");
`endif

endmodule

// ===== rtl/core/tgr_ram.sv =====
module tgr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 96
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/tgr_ctrl.sv =====
module tgr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tgr_pkg::tgr_status_type status,
   output tgr_pkg::tgr_cmd_type    cmd
);
   import tgr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GLYPH,
      ST_EMIT,
      ST_TOTAL
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      accept = req_valid && req_ready;
      cmd.accept = accept;
      cmd.glyph = (state_ff == ST_GLYPH);
      cmd.emit_pixel = (state_ff == ST_EMIT) && status.out_free;
      cmd.emit_total = (state_ff == ST_TOTAL) && status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && status.total) begin
               state_in = ST_TOTAL;
            end else if (accept && status.draw) begin
               state_in = ST_GLYPH;
            end
         end
         ST_GLYPH: begin
            state_in = status.mask_any ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (status.out_free && status.mask_one) begin
               state_in = ST_IDLE;
            end
         end
         ST_TOTAL: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/tgr_dp.sv =====
module tgr_dp #(
   parameter int GLYPH_COUNT = 96,
   parameter int COORD_BITS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tgr_pkg::tgr_cmd_type    cmd,
   output tgr_pkg::tgr_status_type status,
   input  logic [1:0]              req_kind,
   input  logic [7:0]              req_text_byte,
   input  logic [6:0]              req_glyph_index,
   input  logic [15:0]             req_glyph_word,
   input  logic                    csr_write,
   input  logic [2:0]              csr_index,
   input  logic [31:0]             csr_data,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic                    rsp_is_total,
   output logic signed [15:0]      rsp_pixel_x,
   output logic signed [15:0]      rsp_pixel_y,
   output logic [31:0]             rsp_pixel_color,
   output logic signed [15:0]      rsp_total_width,
   output logic                    rsp_last
);
   import tgr_pkg::*;

   // wide enough for a coordinate plus a small offset and the 13-bit frame size
   localparam int CW = ((COORD_BITS > 14) ? COORD_BITS : 14) + 2;
   localparam int AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_FF,
      MODE_ESC
   } mode_type;

   function automatic logic [4:0] pixel_place(input logic [3:0] pos);
      // {row, col} of a glyph bit position
      case (pos)
         4'd14:   pixel_place = {3'd0, 2'd0};
         4'd13:   pixel_place = {3'd0, 2'd1};
         4'd12:   pixel_place = {3'd0, 2'd2};
         4'd11:   pixel_place = {3'd1, 2'd0};
         4'd10:   pixel_place = {3'd1, 2'd1};
         4'd9:    pixel_place = {3'd1, 2'd2};
         4'd8:    pixel_place = {3'd2, 2'd0};
         4'd7:    pixel_place = {3'd2, 2'd1};
         4'd6:    pixel_place = {3'd2, 2'd2};
         4'd5:    pixel_place = {3'd3, 2'd0};
         4'd4:    pixel_place = {3'd3, 2'd1};
         4'd3:    pixel_place = {3'd3, 2'd2};
         4'd2:    pixel_place = {3'd4, 2'd0};
         4'd1:    pixel_place = {3'd4, 2'd1};
         4'd0:    pixel_place = {3'd4, 2'd2};
         default: pixel_place = {3'd0, 2'd0};
      endcase
   endfunction

   // configuration and parser state
   logic [15:0]           origin_x_ff, origin_x_in;
   logic [15:0]           origin_y_ff, origin_y_in;
   logic [12:0]           frame_w_ff, frame_w_in;
   logic [12:0]           frame_h_ff, frame_h_in;
   logic [31:0]           def_color_ff, def_color_in;
   logic [COORD_BITS-1:0] cursor_x_ff, cursor_x_in;
   logic [COORD_BITS-1:0] cursor_y_ff, cursor_y_in;
   logic [31:0]           color_ff, color_in;
   mode_type              mode_ff, mode_in;
   logic [11:0]           digits_ff, digits_in;
   logic [1:0]            count_ff, count_in;

   // per-glyph working registers
   logic                  slot_ok_ff, slot_ok_in;
   logic [CW-1:0]         x_eff_ff, x_eff_in;
   logic [CW-1:0]         y_eff_ff, y_eff_in;
   logic [14:0]           mask_ff, mask_in;
   logic [15:0]           total_ff, total_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_is_total_ff, rsp_is_total_in;
   logic [15:0]           rsp_x_ff, rsp_x_in;
   logic [15:0]           rsp_y_ff, rsp_y_in;
   logic [31:0]           rsp_color_ff, rsp_color_in;
   logic [15:0]           rsp_total_ff, rsp_total_in;
   logic                  rsp_last_ff, rsp_last_in;

   // glyph store
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [AW-1:0]         ram_rd_addr;
   logic [15:0]           ram_rd_data;
   logic [7:0]            slot;

   // byte parser
   logic                  hex_ok;
   logic [3:0]            hex_val;
   logic                  plain;
   logic                  pre_adv;
   logic                  draw;
   mode_type              p_mode;
   logic [11:0]           p_digits;
   logic [1:0]            p_count;
   logic [31:0]           p_color;
   logic [COORD_BITS-1:0] p_cx, p_cy, cx_pre;
   logic [31:0]           esc_color;

   // origins and totals
   logic [CW-1:0]         ox_w, oy_w, csr_org_w;
   logic [COORD_BITS-1:0] cx_end;
   logic [CW-1:0]         tot_w;

   // glyph setup
   logic [15:0]           g;
   logic [COORD_BITS-1:0] y_drop;
   logic [CW-1:0]         xg, yg;
   logic                  has3, has2;
   logic [COORD_BITS-1:0] adv;
   logic [14:0]           wmask, colmask, rowmask, mask_new;
   logic [2:0]            col_ok;
   logic [4:0]            row_ok;
   logic [CW-1:0]         fw_w, fh_w;
   logic [CW-1:0]         pxc [GLYPH_COLS];
   logic [CW-1:0]         pyr [GLYPH_ROWS];

   // pixel emission
   logic [3:0]            hi_pos;
   logic [14:0]           hi_onehot;
   logic [2:0]            pr;
   logic [1:0]            pc;
   logic [CW-1:0]         px_w, py_w;

   assign slot        = req_text_byte - CH_SPACE;
   assign ram_rd_addr = AW'(slot);
   assign ram_wr_addr = AW'(req_glyph_index);
   assign ram_wr_en   = cmd.accept && (req_kind == KIND_GLYPH) &&
                        ({2'b00, req_glyph_index} < 9'(GLYPH_COUNT));

   tgr_ram #(
      .WIDTH (16),
      .DEPTH (GLYPH_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_glyph_word),
      .rd_en   (cmd.accept),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ox_w      = CW'($signed(origin_x_ff));
   assign oy_w      = CW'($signed(origin_y_ff));
   assign csr_org_w = CW'($signed(csr_data[15:0]));
   assign esc_color = {COLOR_ALPHA, digits_ff[3:0], digits_ff[3:0], digits_ff[7:4],
                       digits_ff[7:4], digits_ff[11:8], digits_ff[11:8]};

   always_comb begin
      hex_ok = 1'b1;
      hex_val = '0;
      if (req_text_byte inside {[CH_0:CH_9]}) begin
         hex_val = 4'(req_text_byte - CH_0);
      end else if (req_text_byte inside {[CH_LA:CH_LF]}) begin
         hex_val = 4'(req_text_byte - CH_LA + 8'd10);
      end else if (req_text_byte inside {[CH_UA:CH_UF]}) begin
         hex_val = 4'(req_text_byte - CH_UA + 8'd10);
      end else begin
         hex_ok = 1'b0;
      end
   end

   // text byte: escape handling first, then the byte itself if it falls through
   always_comb begin
      plain = 1'b0;
      pre_adv = 1'b0;
      p_mode = mode_ff;
      p_digits = digits_ff;
      p_count = count_ff;
      p_color = color_ff;
      case (mode_ff)
         MODE_FF: begin
            if (req_text_byte == CH_LPAREN) begin
               p_mode = MODE_ESC;
               p_digits = '0;
               p_count = '0;
            end else begin
               p_mode = MODE_NORMAL;
               pre_adv = 1'b1;
               plain = 1'b1;
            end
         end
         MODE_ESC: begin
            if (req_text_byte == CH_RPAREN) begin
               p_color = (count_ff == 2'd3) ? esc_color : def_color_ff;
               p_mode = MODE_NORMAL;
            end else if ((count_ff == 2'd3) || !hex_ok) begin
               p_color = def_color_ff;
               p_mode = MODE_NORMAL;
               plain = 1'b1;
            end else begin
               p_digits = {digits_ff[7:0], hex_val};
               p_count = count_ff + 2'd1;
            end
         end
         default: begin
            p_mode = MODE_NORMAL;
            plain = 1'b1;
         end
      endcase

      cx_pre = pre_adv ? cursor_x_ff + COORD_BITS'(4) : cursor_x_ff;
      p_cx = cx_pre;
      p_cy = cursor_y_ff;
      draw = 1'b0;
      if (plain) begin
         if (req_text_byte == CH_NEWLINE) begin
            p_cx = ox_w[COORD_BITS-1:0];
            p_cy = cursor_y_ff + COORD_BITS'(6);
         end else if (req_text_byte == CH_FORMFEED) begin
            p_mode = MODE_FF;
         end else if (!(req_text_byte inside {[CH_SPACE:CH_DEL]})) begin
            p_cx = cx_pre + COORD_BITS'(4);
         end else begin
            draw = 1'b1;
         end
      end
   end

   // end of string: a pending form feed still counts as an advance
   always_comb begin
      cx_end = (mode_ff == MODE_FF) ? cursor_x_ff + COORD_BITS'(4) : cursor_x_ff;
      tot_w = CW'($signed(cx_end)) - ox_w;
   end

   // glyph setup: width, drop, clipped pixel mask
   always_comb begin
      g = slot_ok_ff ? ram_rd_data : '0;
      y_drop = g[15] ? cursor_y_ff + COORD_BITS'(1) : cursor_y_ff;
      xg = CW'($signed(cursor_x_ff));
      yg = CW'($signed(y_drop));
      has3 = |(g[14:0] & COL2_BITS);
      has2 = |(g[14:0] & COL1_BITS);
      if ((g == '0) || has3) begin
         adv = COORD_BITS'(4);
      end else if (has2) begin
         adv = COORD_BITS'(3);
      end else begin
         adv = COORD_BITS'(2);
      end
      if (has3) begin
         wmask = COL0_BITS | COL1_BITS | COL2_BITS;
      end else if (has2) begin
         wmask = COL0_BITS | COL1_BITS;
      end else begin
         wmask = COL0_BITS;
      end
      fw_w = CW'(frame_w_ff);
      fh_w = CW'(frame_h_ff);
      for (int c = 0; c < GLYPH_COLS; c++) begin
         pxc[c] = xg + CW'(c);
         col_ok[c] = !pxc[c][CW-1] && (pxc[c] < fw_w);
      end
      for (int r = 0; r < GLYPH_ROWS; r++) begin
         pyr[r] = yg + CW'(r);
         row_ok[r] = !pyr[r][CW-1] && (pyr[r] < fh_w);
      end
      colmask = (col_ok[0] ? COL0_BITS : '0) | (col_ok[1] ? COL1_BITS : '0) |
                (col_ok[2] ? COL2_BITS : '0);
      rowmask = {{3{row_ok[0]}}, {3{row_ok[1]}}, {3{row_ok[2]}},
                 {3{row_ok[3]}}, {3{row_ok[4]}}};
      mask_new = g[14:0] & wmask & colmask & rowmask;
   end

   // next pixel in raster order is the highest set mask bit
   always_comb begin
      hi_pos = '0;
      for (int i = 0; i < 15; i++) begin
         if (mask_ff[i]) begin
            hi_pos = 4'(i);
         end
      end
      hi_onehot = 15'(1) << hi_pos;
      {pr, pc} = pixel_place(hi_pos);
      px_w = x_eff_ff + CW'(pc);
      py_w = y_eff_ff + CW'(pr);
   end

   always_comb begin
      status.draw = (req_kind == KIND_TEXT) && draw;
      status.total = (req_kind == KIND_TOTAL);
      status.mask_any = |mask_new;
      status.mask_one = ((mask_ff & (mask_ff - 15'd1)) == '0);
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      frame_w_in = frame_w_ff;
      frame_h_in = frame_h_ff;
      def_color_in = def_color_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      color_in = color_ff;
      mode_in = mode_ff;
      digits_in = digits_ff;
      count_in = count_ff;
      slot_ok_in = slot_ok_ff;
      x_eff_in = x_eff_ff;
      y_eff_in = y_eff_ff;
      mask_in = mask_ff;
      total_in = total_ff;

      if (csr_write) begin
         case (csr_index)
            REG_ORIGIN_X: begin
               origin_x_in = csr_data[15:0];
               cursor_x_in = csr_org_w[COORD_BITS-1:0];
            end
            REG_ORIGIN_Y: begin
               origin_y_in = csr_data[15:0];
               cursor_y_in = csr_org_w[COORD_BITS-1:0];
            end
            REG_FRAME_WIDTH: begin
               frame_w_in = csr_data[12:0];
            end
            REG_FRAME_HEIGHT: begin
               frame_h_in = csr_data[12:0];
            end
            REG_DEFAULT_COLOR: begin
               def_color_in = csr_data;
               color_in = csr_data;
            end
            default: begin
            end
         endcase
      end

      if (cmd.accept) begin
         case (req_kind)
            KIND_TEXT: begin
               mode_in = p_mode;
               digits_in = p_digits;
               count_in = p_count;
               color_in = p_color;
               cursor_x_in = p_cx;
               cursor_y_in = p_cy;
               slot_ok_in = ({1'b0, slot} < 9'(GLYPH_COUNT));
            end
            KIND_TOTAL: begin
               total_in = tot_w[15:0];
               cursor_x_in = ox_w[COORD_BITS-1:0];
               cursor_y_in = oy_w[COORD_BITS-1:0];
               color_in = def_color_ff;
               mode_in = MODE_NORMAL;
               digits_in = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.glyph) begin
         cursor_x_in = cursor_x_ff + adv;
         x_eff_in = xg;
         y_eff_in = yg;
         mask_in = mask_new;
      end

      if (cmd.emit_pixel) begin
         mask_in = mask_ff & ~hi_onehot;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_is_total_in = rsp_is_total_ff;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.emit_pixel) begin
         rsp_valid_in = 1'b1;
         rsp_is_total_in = 1'b0;
         rsp_x_in = px_w[15:0];
         rsp_y_in = py_w[15:0];
         rsp_color_in = color_ff;
         rsp_total_in = '0;
         rsp_last_in = status.mask_one;
      end else if (cmd.emit_total) begin
         rsp_valid_in = 1'b1;
         rsp_is_total_in = 1'b1;
         rsp_x_in = '0;
         rsp_y_in = '0;
         rsp_color_in = '0;
         rsp_total_in = total_ff;
         rsp_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         frame_w_ff <= 13'd64;
         frame_h_ff <= 13'd64;
         def_color_ff <= 32'hffff_ffff;
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         color_ff <= 32'hffff_ffff;
         mode_ff <= MODE_NORMAL;
         digits_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         frame_w_ff <= frame_w_in;
         frame_h_ff <= frame_h_in;
         def_color_ff <= def_color_in;
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         color_ff <= color_in;
         mode_ff <= mode_in;
         digits_ff <= digits_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ok_ff <= slot_ok_in;
      x_eff_ff <= x_eff_in;
      y_eff_ff <= y_eff_in;
      mask_ff <= mask_in;
      total_ff <= total_in;
      rsp_is_total_ff <= rsp_is_total_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_total    = rsp_is_total_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_total_width = rsp_total_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
